// File: rtl/core/chained_hash_table_defines.svh
// assertion macros for the hash table rtl
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cht_pkg.sv
// shared types and codes for the chained hash table
package cht_pkg;

    localparam int ACT_W  = 2;
    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data_out;
    } t_rsp;

    // free node stack control
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_free_ctl;

endpackage

// File: rtl/core/cht_mod.sv
// bucket index unit: key modulo table size by mask or reciprocal multiply
module cht_mod #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [cht_pkg::KEY_W-1:0]     i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_bucket
);

    localparam int AW = $clog2(TABLE_SIZE);

    if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
        logic          r_done;
        logic [AW-1:0] r_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_go;
            end
            if (i_go) begin
                r_rem <= i_key[AW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end else begin : g_recip
        localparam int KW = cht_pkg::KEY_W;
        localparam int PW = KW + 32;
        localparam int SH = KW + AW;
        // ceil(2^SH / TABLE_SIZE): quotient from the top product bits is exact for any key
        localparam logic [31:0] RECIP =
            32'(((64'd1 << SH) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
        localparam logic [KW-1:0] MODV = KW'(TABLE_SIZE);

        logic          r_mul_vld;
        logic          r_done;
        logic [KW-1:0] r_key;
        logic [KW-1:0] r_quot;
        logic [AW-1:0] r_rem;
        logic [KW-1:0] w_rem;

        // remainder from the registered quotient and key
        assign w_rem = r_key - r_quot * MODV;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mul_vld <= 1'b0;
                r_done    <= 1'b0;
            end else begin
                r_mul_vld <= i_go;
                r_done    <= r_mul_vld;
            end
            if (i_go) begin
                r_key  <= i_key;
                r_quot <= KW'((PW'(i_key) * PW'(RECIP)) >> SH);
            end
            if (r_mul_vld) begin
                r_rem <= w_rem[AW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end

endmodule

// File: rtl/core/cht_free.sv
// free node stack: pop on insert, push on remove and during the clearing pass
module cht_free #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cht_pkg::t_free_ctl            i_ctl,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_push_idx,
    output logic                          o_empty,
    output logic [$clog2(TABLE_SIZE)-1:0] o_top
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    logic [AW-1:0] stk [TABLE_SIZE];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] w_dec;
    logic [AW-1:0] r_top;

    assign w_dec = r_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.push) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_ctl.pop) begin
            r_cnt <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            stk[r_cnt[AW-1:0]] <= i_push_idx;
        end
        if (i_ctl.rd) begin
            r_top <= stk[w_dec[AW-1:0]];
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_top   = r_top;

endmodule

// File: rtl/core/chained_hash_table.sv
// chained hash table top level: sequencer, bucket heads and node store
//
// Keyed table with separate chaining over a pool of TABLE_SIZE nodes. Pulse
// start while busy is low to hand in one request (insert, search or remove);
// exactly one result comes back later as a single-cycle o_valid strobe with
// o_rsp, and the receiver must take it in that cycle since it cannot stall.
// After reset, busy stays high for a clearing pass that nulls every bucket
// head and fills the free node stack. The bucket index comes from a mask of
// the key when TABLE_SIZE is a power of two, else from a reciprocal multiply
// and a remainder step. An insert is refused with full status when the free
// stack is empty; a search or remove walks the chain from its head until a
// key matches or the chain ends (no walk for an empty bucket). The chain walk
// reads one node per cycle from the node store; busy drops in the strobe
// cycle, so the next request can be accepted right then. Duplicate keys are
// allowed; search and remove hit the newest matching node. Action 3 does
// nothing and reports ok.
`include "chained_hash_table_defines.svh"

module chained_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  cht_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output cht_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(TABLE_SIZE + 1);
    // link value that ends a chain
    localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_INS,
        ST_INS_WR,
        ST_HEAD,
        ST_HEAD_CHK,
        ST_WALK
    } t_state;

    // sequencer registers
    t_state        r_state, n_state;
    cht_pkg::t_req r_req, n_req;
    logic [AW-1:0] r_cur, n_cur;         // node whose data sits in the read regs
    logic [AW-1:0] r_prev, n_prev;       // node before r_cur in the chain
    logic          r_prev_null, n_prev_null;
    logic [AW-1:0] r_clr, n_clr;         // clearing pass index
    logic          r_valid, n_valid;
    cht_pkg::t_rsp r_rsp, n_rsp;

    // bucket heads and node store
    logic [LW-1:0]              head_mem [TABLE_SIZE];
    logic [cht_pkg::KEY_W-1:0]  key_mem  [TABLE_SIZE];
    logic [cht_pkg::DATA_W-1:0] data_mem [TABLE_SIZE];
    logic [LW-1:0]              next_mem [TABLE_SIZE];

    logic [LW-1:0]              r_head_q;
    logic [cht_pkg::KEY_W-1:0]  r_key_q;
    logic [cht_pkg::DATA_W-1:0] r_data_q;
    logic [LW-1:0]              r_next_q;

    // memory port controls
    logic [AW-1:0] w_head_ra;
    logic          w_head_we;
    logic [AW-1:0] w_head_wa;
    logic [LW-1:0] w_head_wd;
    logic [AW-1:0] w_node_ra;
    logic          w_node_we;
    logic          w_next_we;
    logic [AW-1:0] w_next_wa;
    logic [LW-1:0] w_next_wd;

    // hash unit and free stack
    logic               w_hash_go;
    logic               w_hash_done;
    logic [AW-1:0]      w_bucket;
    cht_pkg::t_free_ctl w_free_ctl;
    logic [AW-1:0]      w_push_idx;
    logic               w_free_empty;
    logic [AW-1:0]      w_free_top;

    assign busy      = (r_state != ST_IDLE);
    assign w_hash_go = start && (r_state == ST_IDLE);

    cht_mod #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_hash_go),
        .i_key   (i_req.key),
        .o_done  (w_hash_done),
        .o_bucket(w_bucket)
    );

    cht_free #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_free (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_free_ctl),
        .i_push_idx(w_push_idx),
        .o_empty   (w_free_empty),
        .o_top     (w_free_top)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_null = r_prev_null;
        n_clr       = r_clr;
        n_valid     = 1'b0;
        n_rsp       = r_rsp;

        w_head_ra  = w_bucket;
        w_head_we  = 1'b0;
        w_head_wa  = w_bucket;
        w_head_wd  = NULL_LINK;
        w_node_ra  = r_cur;
        w_node_we  = 1'b0;
        w_next_we  = 1'b0;
        w_next_wa  = w_free_top;
        w_next_wd  = r_head_q;
        w_free_ctl = '0;
        w_push_idx = r_cur;

        case (r_state)
            ST_CLEAR: begin
                // null one head and hand one node to the free stack per cycle
                w_head_we       = 1'b1;
                w_head_wa       = r_clr;
                w_head_wd       = NULL_LINK;
                w_free_ctl.push = 1'b1;
                w_push_idx      = r_clr;
                n_clr           = r_clr + AW'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (w_hash_done) begin
                    case (r_req.action)
                        cht_pkg::ACT_INSERT: begin
                            n_state = ST_INS;
                        end
                        cht_pkg::ACT_SEARCH, cht_pkg::ACT_REMOVE: begin
                            n_state = ST_HEAD;
                        end
                        default: begin
                            // unused action: no change, plain ok
                            n_valid = 1'b1;
                            n_rsp   = '{status: cht_pkg::STAT_OK, data_out: '0};
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                if (w_free_empty) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: cht_pkg::STAT_FULL, data_out: '0};
                    n_state = ST_IDLE;
                end else begin
                    // head read and free stack top land together
                    w_free_ctl.rd = 1'b1;
                    n_state       = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                // push the new node at the head of its chain
                w_node_we      = 1'b1;
                w_next_we      = 1'b1;
                w_next_wa      = w_free_top;
                w_next_wd      = r_head_q;
                w_head_we      = 1'b1;
                w_head_wa      = w_bucket;
                w_head_wd      = LW'(w_free_top);
                w_free_ctl.pop = 1'b1;
                n_valid        = 1'b1;
                n_rsp          = '{status: cht_pkg::STAT_OK, data_out: '0};
                n_state        = ST_IDLE;
            end
            ST_HEAD: begin
                n_state = ST_HEAD_CHK;
            end
            ST_HEAD_CHK: begin
                if (r_head_q >= NULL_LINK) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: cht_pkg::STAT_MISS, data_out: '0};
                    n_state = ST_IDLE;
                end else begin
                    w_node_ra   = r_head_q[AW-1:0];
                    n_cur       = r_head_q[AW-1:0];
                    n_prev_null = 1'b1;
                    n_state     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_key_q == r_req.key) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req.action == cht_pkg::ACT_SEARCH) begin
                        n_rsp = '{status: cht_pkg::STAT_OK, data_out: r_data_q};
                    end else begin
                        // unlink the hit and return it to the pool
                        n_rsp = '{status: cht_pkg::STAT_OK, data_out: '0};
                        if (r_prev_null) begin
                            w_head_we = 1'b1;
                            w_head_wa = w_bucket;
                            w_head_wd = r_next_q;
                        end else begin
                            w_next_we = 1'b1;
                            w_next_wa = r_prev;
                            w_next_wd = r_next_q;
                        end
                        w_free_ctl.push = 1'b1;
                        w_push_idx      = r_cur;
                    end
                end else if (r_next_q >= NULL_LINK) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: cht_pkg::STAT_MISS, data_out: '0};
                    n_state = ST_IDLE;
                end else begin
                    // follow the link, one node per cycle
                    w_node_ra   = r_next_q[AW-1:0];
                    n_cur       = r_next_q[AW-1:0];
                    n_prev      = r_cur;
                    n_prev_null = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_req       <= n_req;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_null <= n_prev_null;
        r_rsp       <= n_rsp;
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            head_mem[w_head_wa] <= w_head_wd;
        end
        r_head_q <= head_mem[w_head_ra];
    end

    // node store
    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            key_mem[w_free_top]  <= r_req.key;
            data_mem[w_free_top] <= r_req.payload;
        end
        if (w_next_we) begin
            next_mem[w_next_wa] <= w_next_wd;
        end
        r_key_q  <= key_mem[w_node_ra];
        r_data_q <= data_mem[w_node_ra];
        r_next_q <= next_mem[w_node_ra];
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `CHT_ASSERT_NOW(a_strobe_idle, o_valid, !busy, "result strobe while busy")
    `CHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `CHT_ASSERT_NEXT(a_one_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `CHT_ASSERT_NOW(a_data_zero, o_valid && (o_rsp.status != cht_pkg::STAT_OK), o_rsp.data_out == '0, "nonzero data on failed request")

endmodule

// File: sim/tb.sv
// testbench for the chained hash table: shadow table, request driver, result checker
`timescale 1ns / 100ps

module tb;
    import cht_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int NULL_LINK  = TABLE_SIZE;
    localparam int N_BLOCKS   = 10;   // random part: blocks of requests
    localparam int BLOCK_LEN  = 50;
    localparam int MAX_GAP    = 17;
    localparam int STALL_MAX  = 1000; // cycles with no request and no result
    localparam int SETTLE     = 40;   // quiet cycles after the last result

    // one request waiting for its result, with what the result must be
    typedef struct {
        t_req req;
        t_rsp rsp;
    } t_due;

    // shadow of the table plus the queue of results still owed by the block
    class table_shadow;
        int                head [TABLE_SIZE];
        logic [KEY_W-1:0]  node_key [TABLE_SIZE];
        logic [DATA_W-1:0] node_data [TABLE_SIZE];
        int                node_next [TABLE_SIZE];
        bit                node_used [TABLE_SIZE];
        int                entries;
        t_due              owed [$];
        int                errors;
        // what the run went through
        int n_stored, n_full, n_found, n_missed, n_removed, n_other, deepest;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                head[i]      = NULL_LINK;
                node_key[i]  = '0;
                node_data[i] = '0;
                node_next[i] = 0;
                node_used[i] = 1'b0;
            end
            entries = 0;
            errors  = 0;
            {n_stored, n_full, n_found, n_missed, n_removed, n_other, deepest} = '0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // apply one request to the shadow table and return the result it must give
        function t_rsp apply(t_req r);
            t_rsp res;
            int   bkt, cur, prev, hit, n, steps;
            res.status   = STAT_OK;
            res.data_out = '0;
            bkt = int'(r.key % TABLE_SIZE);
            if (r.action == ACT_INSERT) begin
                // lowest free node, unless the count already says full
                n = NULL_LINK;
                if (entries < TABLE_SIZE) begin
                    for (n = 0; n < TABLE_SIZE; n++)
                        if (!node_used[n]) break;
                end
                if (n >= TABLE_SIZE) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    node_key[n]  = r.key;
                    node_data[n] = r.payload;
                    node_next[n] = head[bkt];
                    node_used[n] = 1'b1;
                    head[bkt]    = n;
                    entries++;
                    n_stored++;
                end
            end else if (r.action == ACT_SEARCH || r.action == ACT_REMOVE) begin
                // walk from the head, newest node first, stopping at a bad link
                cur  = head[bkt];
                prev = NULL_LINK;
                hit  = NULL_LINK;
                for (steps = 0; steps < TABLE_SIZE && cur < TABLE_SIZE; steps++) begin
                    if (node_key[cur] == r.key) begin
                        hit = cur;
                        break;
                    end
                    prev = cur;
                    cur  = node_next[cur];
                end
                if (steps + 1 > deepest && hit < TABLE_SIZE) deepest = steps + 1;
                if (hit >= TABLE_SIZE) begin
                    res.status = STAT_MISS;
                    n_missed++;
                end else if (r.action == ACT_SEARCH) begin
                    res.data_out = node_data[hit];
                    n_found++;
                end else begin
                    if (prev < TABLE_SIZE) node_next[prev] = node_next[hit];
                    else head[bkt] = node_next[hit];
                    node_used[hit] = 1'b0;
                    if (entries > 0) entries--;
                    n_removed++;
                end
            end else begin
                n_other++;
            end
            return res;
        endfunction

        // a request was taken by the block
        function void note_request(t_req r);
            t_due d;
            d.req = r;
            d.rsp = apply(r);
            owed.push_back(d);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] %s", $realtime, msg);
        endfunction

        // a result strobe came out of the block
        function void check_response(t_rsp got);
            t_due d;
            if (owed.size() == 0) begin
                flag($sformatf("result with no request waiting: status %0d data %h",
                               got.status, got.data_out));
                return;
            end
            d = owed.pop_front();
            if (got.status !== d.rsp.status)
                flag($sformatf("action %0d key %h: status expected %0d, got %0d",
                               d.req.action, d.req.key, d.rsp.status, got.status));
            if (got.data_out !== d.rsp.data_out)
                flag($sformatf("action %0d key %h: data expected %h, got %h",
                               d.req.action, d.req.key, d.rsp.data_out, got.data_out));
        endfunction

        // some key that is stored right now, for searches and removes that hit
        function bit pick_live(output logic [KEY_W-1:0] k);
            int idx [$];
            k = '0;
            for (int i = 0; i < TABLE_SIZE; i++)
                if (node_used[i]) idx.push_back(i);
            if (idx.size() == 0) return 1'b0;
            k = node_key[idx[$urandom_range(0, idx.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    table_shadow shadow = new();
    logic [KEY_W-1:0] key_pool [24];
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    chained_hash_table #(
        .TABLE_SIZE(TABLE_SIZE)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    // results cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) shadow.check_response(o_rsp);
    end

    // watchdog: cycles in which neither a request nor a result moved
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_MAX) begin
                $display("timeout: nothing moved for %0d cycles, %0d results owed",
                         STALL_MAX, shadow.pending());
                $display("** chained_hash_table: FAILED **");
                $finish;
            end
        end
    end

    function t_req make_req(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                            logic [DATA_W-1:0] pl);
        t_req r;
        r.action  = act;
        r.key     = k;
        r.payload = pl;
        return r;
    endfunction

    // hand one request in after gap idle cycles; start stays high afterwards
    // so a following request with no gap goes in back to back
    task automatic send(t_req r, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        shadow.note_request(r);
    endtask

    // hold off until every owed result has come back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req             r;
        logic [KEY_W-1:0] k;
        int               roll, gap;
        bit               fill_phase, burst;

        // keys crowded into a few buckets so chains grow and duplicates occur
        foreach (key_pool[i])
            key_pool[i] = {27'(($urandom_range(0, 3) == 0) ? $urandom() :
                               $urandom_range(0, 7)),
                           4'(i % 5)};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, unused action, extremes, duplicates, unlinks
        send(make_req(ACT_SEARCH, 31'd0, '0), 0);                     // empty bucket
        send(make_req(ACT_REMOVE, 31'd5, '0), 3);                     // absent remove
        send(make_req(ACT_NOP, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0);     // unused action
        send(make_req(ACT_INSERT, 31'd0, 32'h0000_0000), 1);
        send(make_req(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0);
        send(make_req(ACT_INSERT, 31'd16, 32'h1234_5678), 0);         // same bucket as 0
        send(make_req(ACT_INSERT, 31'd0, 32'hA5A5_A5A5), 17);         // duplicate key
        send(make_req(ACT_SEARCH, 31'd0, '0), 0);                     // newest copy
        send(make_req(ACT_REMOVE, 31'd0, '0), 2);                     // head unlink
        send(make_req(ACT_SEARCH, 31'd0, '0), 0);                     // older copy now
        send(make_req(ACT_REMOVE, 31'd16, '0), 0);                    // head unlink
        send(make_req(ACT_SEARCH, 31'h7FFF_FFFF, '0), 5);
        send(make_req(ACT_SEARCH, 31'd32, '0), 0);                    // walk, then miss
        // fill the pool through one long chain, then one insert too many
        for (int i = 0; i < TABLE_SIZE - 2; i++)
            send(make_req(ACT_INSERT, 31'(15 + 16 * i), $urandom()), i % 2);
        send(make_req(ACT_INSERT, 31'd99, 32'hDEAD_BEEF), 0);         // table full
        send(make_req(ACT_SEARCH, 31'd15, '0), 0);                    // node next to the tail
        send(make_req(ACT_REMOVE, 31'd15, '0), 0);                    // middle unlink
        drain();

        // random blocks alternate between filling and draining the table;
        // some run back to back, the rest with random gaps
        for (int b = 0; b < N_BLOCKS; b++) begin
            fill_phase = (b % 2 == 0);
            burst      = (b % 3 == 1);
            for (int j = 0; j < BLOCK_LEN; j++) begin
                roll = $urandom_range(0, 99);
                if (fill_phase)
                    r.action = (roll < 55) ? ACT_INSERT : (roll < 77) ? ACT_SEARCH :
                               (roll < 95) ? ACT_REMOVE : ACT_NOP;
                else
                    r.action = (roll < 20) ? ACT_INSERT : (roll < 47) ? ACT_SEARCH :
                               (roll < 95) ? ACT_REMOVE : ACT_NOP;
                roll = $urandom_range(0, 9);
                if (roll < 5 || (roll < 8 && !shadow.pick_live(k)))
                    k = key_pool[$urandom_range(0, 23)];
                else if (roll >= 8)
                    k = 31'($urandom());
                r.key     = k;
                r.payload = $urandom();
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
                send(r, gap);
            end
            if (b % 2 == 1) drain();
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("inserts stored %0d, refused full %0d, searches found %0d, misses %0d",
                 shadow.n_stored, shadow.n_full, shadow.n_found, shadow.n_missed);
        $display("removes done %0d, unused actions %0d, longest chain walk %0d nodes",
                 shadow.n_removed, shadow.n_other, shadow.deepest);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("** chained_hash_table: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never came", shadow.errors,
                     shadow.pending());
            $display("** chained_hash_table: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cht_pkg.sv
rtl/core/cht_mod.sv
rtl/core/cht_free.sv
rtl/core/chained_hash_table.sv
sim/tb.sv
